// File: sv/lsp_pkg.sv
// shared types, codes and sizes for the lifo stack with peek
`timescale 1ns / 1ps
package lsp_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 5;
	localparam int CAP_W  = 5;
	localparam int ST_W   = 2;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_W   = CMD_W + WORD_W + POS_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_OVER   = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDER  = 2'd2;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

	// register index (byte address bit 2)
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic exec_next;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd_valid;
		logic more;
	} dp_stat_t;

endpackage

// File: sv/lsp_dp.sv
// stack datapath: entry memory, occupancy count, address and status logic
`timescale 1ns / 1ps
module lsp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsp_pkg::dp_cmd_t            cmd,
	output lsp_pkg::dp_stat_t           stat,
	input  logic [lsp_pkg::IN_W-1:0]    in_word,
	input  logic [lsp_pkg::CAP_W-1:0]   capacity,
	output logic [lsp_pkg::WORD_W-1:0]  data,
	output logic [lsp_pkg::ST_W-1:0]    status,
	output logic                        last
);
	import lsp_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [WORD_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ST_W-1:0]   status_q;
	logic              last_q;
	logic              zero_q;

	logic [ST_W-1:0]   st_c;
	logic              last_c;
	logic              zero_c;
	logic              we_c;
	logic              re_c;
	logic [ADDR_W-1:0] addr_c;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  peek_diff;
	logic              empty;
	logic              full;
	logic              bad_pos;
	logic              do_exec;

	assign do_exec   = cmd.exec | cmd.exec_next;
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_ext   = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(pos_q);
	assign cap_ext   = CMP_W'(capacity);
	assign peek_diff = cnt_ext - pos_ext;
	assign empty     = (count_q == '0);
	// capacity above the array depth is limited by the array itself
	assign full      = (cnt_ext >= cap_ext) || (count_q == CNT_W'(DEPTH));
	assign bad_pos   = (pos_q == '0) || (pos_ext > cnt_ext);

	always_comb begin
		st_c    = ST_OK;
		last_c  = 1'b1;
		zero_c  = 1'b1;
		we_c    = 1'b0;
		re_c    = 1'b0;
		addr_c  = '0;
		cnt_nxt = count_q;
		if (cmd.exec_next) begin
			// next dump entry, one below the last one read
			addr_c = idx_q - ADDR_W'(1);
			re_c   = 1'b1;
			zero_c = 1'b0;
			last_c = (addr_c == '0);
		end else begin
			case (cmd_q)
				CMD_PUSH: begin
					if (full) begin
						st_c = ST_OVER;
					end else begin
						we_c    = 1'b1;
						addr_c  = count_q[ADDR_W-1:0];
						cnt_nxt = count_q + CNT_W'(1);
					end
				end
				CMD_PEEK: begin
					if (bad_pos) begin
						st_c = ST_BADPOS;
					end else begin
						re_c   = 1'b1;
						zero_c = 1'b0;
						addr_c = peek_diff[ADDR_W-1:0];
					end
				end
				CMD_POP, CMD_TOP, CMD_BOTTOM, CMD_DUMP: begin
					if (empty) begin
						st_c = ST_UNDER;
					end else begin
						re_c   = 1'b1;
						zero_c = 1'b0;
						addr_c = (cmd_q == CMD_BOTTOM) ? '0 : cnt_m1[ADDR_W-1:0];
						if (cmd_q == CMD_POP) begin
							cnt_nxt = cnt_m1;
						end
						if (cmd_q == CMD_DUMP) begin
							last_c = (cnt_m1 == '0);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_word[CMD_W-1:0];
			val_q <= in_word[CMD_W+WORD_W-1:CMD_W];
			pos_q <= in_word[IN_W-1:CMD_W+WORD_W];
		end
		if (do_exec) begin
			status_q <= st_c;
			last_q   <= last_c;
			zero_q   <= zero_c;
			idx_q    <= addr_c;
		end
	end

	// entry memory, one port, registered read
	always_ff @(posedge clk) begin
		if (do_exec && we_c) begin
			mem[addr_c] <= val_q;
		end
		if (do_exec && re_c) begin
			rdata_q <= mem[addr_c];
		end
	end

	assign data   = zero_q ? '0 : rdata_q;
	assign status = status_q;
	assign last   = last_q;

	assign stat.cmd_valid = (cmd_q <= CMD_DUMP);
	assign stat.more      = (cmd_q == CMD_DUMP) && (status_q == ST_OK) && !last_q;

endmodule

// File: sv/lsp_ctrl.sv
// stack controller: sequences accept, execute and result handoff
`timescale 1ns / 1ps
module lsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output lsp_pkg::dp_cmd_t   cmd,
	input  lsp_pkg::dp_stat_t  stat
);
	import lsp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = stat.cmd_valid ? S_OUT : S_IDLE;
			end
			S_DUMP: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (m_tready) state_nxt = stat.more ? S_DUMP : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		m_tvalid      = 1'b0;
		cmd.load      = 1'b0;
		cmd.exec      = 1'b0;
		cmd.exec_next = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_DUMP: cmd.exec_next = 1'b1;
			S_OUT:  m_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

// File: sv/lifo_stack_with_peek.sv
// top level of the lifo stack with peek: stream ports, register port, assertions
`timescale 1ns / 1ps
// usage
//   slave stream carries one command word: command, push value and peek position
//   master stream returns result words: read data, status in tuser, tlast on the
//   final word caused by a command
//   apb register 0 holds capacity (reset 16); write it only while the block is idle
// sequencing
//   one command at a time: accept state, execute state (memory access), then the
//   result sits in the output register until the receiver takes it; a dump
//   alternates a read state and the output state for each entry, each read going
//   through the single registered read port of the entry memory
//   command codes 6 and 7 give no word
// reset and stall
//   reset empties the stack (count zero) and restores capacity; entry contents
//   are not cleared, they are only read once written
//   while the receiver stalls the result word holds and no command is accepted
module lifo_stack_with_peek (
	input  logic                        clk,
	input  logic                        arst_n,
	// command word, lsb up: command[2:0], push_value[34:3], position[39:35]
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lsp_pkg::IN_TW-1:0]   s_tdata,
	// result word, lsb up: data[31:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lsp_pkg::WORD_W-1:0]  m_tdata,
	// result flags, lsb up: status[1:0]
	output logic [lsp_pkg::ST_W-1:0]    m_tuser,
	output logic                        m_tlast,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lsp_pkg::*;

	dp_cmd_t          dp_cmd;
	dp_stat_t         dp_stat;
	logic [CAP_W-1:0] capacity_q;
	logic             cfg_wr;

	// register port, zero wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// addresses beyond the register list read as zero
	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_q} : '0;

	lsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

	lsp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.in_word  (s_tdata[IN_W-1:0]),
		.capacity (capacity_q),
		.data     (m_tdata),
		.status   (m_tuser),
		.last     (m_tlast)
	);

	// no command taken while a result word is pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("command accepted while a result is pending");

	// an error result always ends its command and carries zero data
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata == '0)))
		else $error("error result not final or carries data");

	// after a non-final dump word is taken, the next word follows once the dump read state has passed
	a_dump_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> ##1 m_tvalid)
		else $error("dump sequence broken");

endmodule

// File: tb/tb_lifo_stack_with_peek.sv
// self-checking testbench for the lifo stack with peek: stream and register stimulus, shadow stack
`timescale 1ns / 1ps
module tb_lifo_stack_with_peek;
	import lsp_pkg::*;

	// codes the block has no meaning for, sent to check that they are dropped
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	// register map: index 0 at byte 0, index 1 is not a register
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;
	localparam logic [2:0] ADDR_UNUSED   = 3'd4;

	localparam int CYCLE_LIMIT      = 1500000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int HOLD_CYCLES      = 300;
	localparam int WORDS_PER_PHASE  = 90;
	localparam int HOLD_BURST       = 24;

	// shadow of the stack: predicts every result word from the accepted commands
	class stack_scoreboard;
		typedef struct {
			logic [WORD_W-1:0] data;
			logic [ST_W-1:0]   status;
			logic              last;
		} result_t;

		logic [WORD_W-1:0] shadow_entries[DEPTH];
		int unsigned       shadow_count;
		logic [CAP_W-1:0]  shadow_cap;
		result_t           expected_words[$];
		int                mismatches;
		int                words_checked;
		int                commands_noted;

		function new();
			shadow_count   = 0;
			shadow_cap     = CAP_RESET;
			mismatches     = 0;
			words_checked  = 0;
			commands_noted = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			shadow_cap = value;
		endfunction

		function int unsigned occupancy();
			return shadow_count;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void expect_word(logic [WORD_W-1:0] data, logic [ST_W-1:0] status, logic last);
			result_t w;
			w.data   = data;
			w.status = status;
			w.last   = last;
			expected_words.push_back(w);
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value,
				logic [POS_W-1:0] pos);
			int unsigned usable;
			usable = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
			commands_noted++;
			case (cmd)
				CMD_PUSH: begin
					if (shadow_count >= usable) begin
						expect_word('0, ST_OVER, 1'b1);
					end else begin
						shadow_entries[shadow_count] = value;
						shadow_count++;
						expect_word('0, ST_OK, 1'b1);
					end
				end
				CMD_POP: begin
					if (shadow_count == 0) begin
						expect_word('0, ST_UNDER, 1'b1);
					end else begin
						shadow_count--;
						expect_word(shadow_entries[shadow_count], ST_OK, 1'b1);
					end
				end
				CMD_PEEK: begin
					if (pos < 1 || pos > shadow_count)
						expect_word('0, ST_BADPOS, 1'b1);
					else
						expect_word(shadow_entries[shadow_count - pos], ST_OK, 1'b1);
				end
				CMD_TOP: begin
					if (shadow_count == 0)
						expect_word('0, ST_UNDER, 1'b1);
					else
						expect_word(shadow_entries[shadow_count - 1], ST_OK, 1'b1);
				end
				CMD_BOTTOM: begin
					if (shadow_count == 0)
						expect_word('0, ST_UNDER, 1'b1);
					else
						expect_word(shadow_entries[0], ST_OK, 1'b1);
				end
				CMD_DUMP: begin
					if (shadow_count == 0) begin
						expect_word('0, ST_UNDER, 1'b1);
					end else begin
						for (int i = 0; i < shadow_count; i++)
							expect_word(shadow_entries[shadow_count - 1 - i], ST_OK,
								(i + 1 == shadow_count));
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(logic [WORD_W-1:0] data, logic [ST_W-1:0] status, logic last);
			result_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, got data %h status %0d last %0d",
					$time, data, status, last);
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (want.data !== data || want.status !== status || want.last !== last) begin
				mismatches++;
				$display({"%0t: mismatch, expected data %h status %0d last %0d,",
					" got data %h status %0d last %0d"},
					$time, want.data, want.status, want.last, data, status, last);
			end
		endfunction
	endclass

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// command side
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata  = '0;
	// result side
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;
	logic [ST_W-1:0]   m_tuser;
	logic              m_tlast;
	// register port
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [2:0]        paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	lifo_stack_with_peek dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	stack_scoreboard sb = new();

	// pacing knobs, percent of cycles spent idle or stalled
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// each bump asks the receiver for one long hold-off
	int hold_request   = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int random_cap     = 0;

	// receiver: checks every accepted word, stalls at random or for a long hold
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
		if (hold_request != hold_served) begin
			hold_served = hold_request;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: ends the run if the block hangs or words go missing
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
		$display("tb_lifo_stack_with_peek: errors");
		$finish;
	end

	// offer one command word; valid stays high afterwards so back-to-back words flow
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] value,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TW'({pos, value, cmd});
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, value, pos);
	endtask

	// stop offering, let every expected word drain, then give dropped codes time to retire
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access until pready
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_CAPACITY)
			sb.set_capacity(value[CAP_W-1:0]);
	endtask

	// random command, biased toward pushes so the stack fills and overflows
	task automatic send_random_command();
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] value;
		logic [POS_W-1:0]  pos;
		int                r;
		int unsigned       depth;
		r     = $urandom_range(99);
		depth = sb.occupancy();
		if (r < ((depth < 4) ? 50 : 40))
			cmd = CMD_PUSH;
		else if (r < 55)
			cmd = CMD_POP;
		else if (r < 75)
			cmd = CMD_PEEK;
		else if (r < 83)
			cmd = CMD_TOP;
		else if (r < 90)
			cmd = CMD_BOTTOM;
		else if (r < 96)
			cmd = CMD_DUMP;
		else
			cmd = r[0] ? CMD_RSVD6 : CMD_RSVD7;
		case ($urandom_range(9))
			0: value = 32'h8000_0000;
			1: value = 32'h7FFF_FFFF;
			2: value = 32'hFFFF_FFFF;
			3: value = '0;
			default: value = $urandom();
		endcase
		// peek mostly near the live range, sometimes anywhere the field allows
		if ($urandom_range(3) == 0)
			pos = POS_W'($urandom_range(31));
		else
			pos = POS_W'($urandom_range(depth + 1));
		send_command(cmd, value, pos);
	endtask

	initial begin : stimulus
		int phase;
		logic [CAP_W-1:0] cap_value;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty stack at reset capacity: every read reports underflow, peek a bad position
		send_command(CMD_POP, '0, '0);
		send_command(CMD_TOP, '0, '0);
		send_command(CMD_BOTTOM, '0, '0);
		send_command(CMD_DUMP, '0, '0);
		send_command(CMD_PEEK, '0, 5'd1);
		// dropped codes, all other fields set
		send_command(CMD_RSVD6, 32'hFFFF_FFFF, 5'd31);
		send_command(CMD_RSVD7, 32'hFFFF_FFFF, 5'd31);
		// extremes of the word
		send_command(CMD_PUSH, 32'h8000_0000, '0);
		send_command(CMD_PUSH, 32'h7FFF_FFFF, 5'd31);
		send_command(CMD_PUSH, '0, '0);
		send_command(CMD_PUSH, 32'hFFFF_FFFF, '0);
		// peek at zero, top, bottom, one too deep and the field maximum
		send_command(CMD_PEEK, '0, 5'd0);
		send_command(CMD_PEEK, '0, 5'd1);
		send_command(CMD_PEEK, '0, 5'd4);
		send_command(CMD_PEEK, '0, 5'd5);
		send_command(CMD_PEEK, '0, 5'd31);
		send_command(CMD_TOP, '0, '0);
		send_command(CMD_BOTTOM, '0, '0);
		send_command(CMD_DUMP, '0, '0);
		send_command(CMD_POP, '0, '0);

		// capacity below the occupancy: push overflows, reads still work
		wait_idle();
		write_reg(ADDR_CAPACITY, 32'd2);
		send_command(CMD_PUSH, 32'h1234_5678, '0);
		send_command(CMD_PEEK, '0, 5'd3);
		// capacity zero: every push overflows
		wait_idle();
		write_reg(ADDR_CAPACITY, 32'd0);
		send_command(CMD_PUSH, 32'h0BAD_F00D, '0);
		// a write past the only register must leave capacity alone
		wait_idle();
		write_reg(ADDR_UNUSED, 32'd16);
		send_command(CMD_PUSH, 32'h0BAD_F00D, '0);
		send_command(CMD_POP, '0, '0);

		// random phases: pacing and capacity change only while the block is idle
		for (phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
					cap_value = 5'd16;
				end
				1: begin
					send_idle_pct = 83;
					recv_stall_pct <= 0;
					cap_value = 5'd1;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 83;
					cap_value = 5'd31;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct <= 33;
					cap_value = CAP_W'($urandom_range(31));
					random_cap = int'(cap_value);
				end
			endcase
			write_reg(ADDR_CAPACITY, 32'(cap_value));
			if (phase == 0) begin
				// receiver holds off long while words keep coming, so the input backs up
				hold_request <= hold_request + 1;
				repeat (HOLD_BURST) send_random_command();
			end
			repeat (WORDS_PER_PHASE) send_random_command();
		end

		// drain and let the block settle before the verdict
		wait_idle();
		$display("covered %0d commands and %0d result words under capacities %s%0d,",
			sb.commands_noted, sb.words_checked, "0, 1, 2, 16, 31 and ", random_cap);
		$display("with idle and stall phases, a %0d-cycle receiver hold and dumps of a full stack",
			HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_lifo_stack_with_peek: clean");
		end else begin
			$display("tb_lifo_stack_with_peek: errors");
		end
		$finish;
	end

endmodule
